/* hw/rtl/zcdp_pkg.sv */
// Shared types, constants and helper functions for the ZIP central directory parser.
// No dependencies; every other RTL file imports this package.
`default_nettype none
package zcdp_pkg;

    localparam int NAME_LIMIT = 256;
    localparam int EMIT_W     = $clog2(NAME_LIMIT);
    localparam int POS_W      = 18;

    localparam logic [31:0] SIG_CENTRAL    = 32'h02014b50;
    localparam logic [31:0] SIZE_ESCAPE    = 32'hFFFFFFFF;
    localparam logic [31:0] UNPACK_DEFAULT = 32'h10000000;

    // Header field byte positions (last byte of each field; first name byte for POS_NAME)
    localparam logic [POS_W-1:0] POS_SIG     = 18'd3;
    localparam logic [POS_W-1:0] POS_FLAGS   = 18'd9;
    localparam logic [POS_W-1:0] POS_METHOD  = 18'd11;
    localparam logic [POS_W-1:0] POS_CRC     = 18'd19;
    localparam logic [POS_W-1:0] POS_PACKED  = 18'd23;
    localparam logic [POS_W-1:0] POS_UNPACK  = 18'd27;
    localparam logic [POS_W-1:0] POS_NAMELEN = 18'd29;
    localparam logic [POS_W-1:0] POS_EXTRA   = 18'd31;
    localparam logic [POS_W-1:0] POS_COMMENT = 18'd33;
    localparam logic [POS_W-1:0] POS_OFFSET  = 18'd45;
    localparam logic [POS_W-1:0] POS_NAME    = 18'd46;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_ENTRY_COUNT    = 2'd0;
    localparam logic [1:0] REG_DIRECTORY_SIZE = 2'd1;
    localparam logic [1:0] REG_MAX_UNPACKED   = 2'd2;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_SKIP   = 2'd2;
    localparam logic [1:0] KIND_FAULT  = 2'd3;

    localparam logic [3:0] SKIP_NONE      = 4'd0;
    localparam logic [3:0] SKIP_ENCRYPTED = 4'd1;
    localparam logic [3:0] SKIP_METHOD    = 4'd2;
    localparam logic [3:0] SKIP_ESCAPE    = 4'd3;
    localparam logic [3:0] SKIP_TOO_LARGE = 4'd4;
    localparam logic [3:0] SKIP_NAME_LEN  = 4'd5;
    localparam logic [3:0] SKIP_EMPTY     = 4'd6;
    localparam logic [3:0] SKIP_DIRECTORY = 4'd7;
    localparam logic [3:0] SKIP_STORE     = 4'd8;

    localparam logic [1:0] FAULT_SIGNATURE = 2'd1;
    localparam logic [1:0] FAULT_OVERRUN   = 2'd2;

    localparam logic [15:0] METHOD_STORE   = 16'd0;
    localparam logic [15:0] METHOD_DEFLATE = 16'd8;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_DOT  = 2'd1,
        PH_COPY = 2'd2,
        PH_STOP = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic              pending_dot;
        logic [EMIT_W-1:0] emitted;
        logic [7:0]        last_char;
        logic [1:0]        qlen;
        logic [7:0]        q0;
        logic [7:0]        q1;
    } norm_state_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [31:0]      header_shift;
        logic [15:0]      flag_word;
        logic [15:0]      method_word;
        logic [31:0]      crc_hold;
        logic [31:0]      packed_hold;
        logic [31:0]      unpacked_hold;
        logic [15:0]      name_bytes;
        logic [15:0]      extra_bytes;
        logic [15:0]      comment_bytes;
        logic [31:0]      offset_hold;
        logic [3:0]       skip_code;
        norm_state_t      norm;
    } rec_t;

    typedef struct packed {
        logic [15:0] entry_count;
        logic [31:0] directory_size;
        logic [31:0] max_unpacked;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_char;
        logic [15:0] entry_number;
        logic        is_deflate;
        logic [31:0] crc_value;
        logic [31:0] packed_size;
        logic [31:0] unpacked_size;
        logic [31:0] header_offset;
        logic [7:0]  name_length;
        logic [3:0]  skip_reason;
        logic [1:0]  fault_code;
        logic        last;
    } res_t;

    function automatic logic is_slash(input logic [7:0] b);
        return (b == CH_SLASH) || (b == CH_BACKSLASH);
    endfunction

    // Map and queue one name character, honoring the name limit
    function automatic norm_state_t produce_char(input norm_state_t s, input logic [7:0] c);
        norm_state_t r;
        logic [7:0]  m;
        r = s;
        m = c;
        if (s.emitted >= EMIT_W'(NAME_LIMIT - 1))
        begin
            r.phase = PH_STOP;
        end
        else
        begin
            if (m == CH_BACKSLASH)
            begin
                m = CH_SLASH;
            end
            if (m >= CH_UPPER_A && m <= CH_UPPER_Z)
            begin
                m = m + CASE_OFFSET;
            end
            if (s.qlen == 2'd0)
            begin
                r.q0   = m;
                r.qlen = 2'd1;
            end
            else if (s.qlen == 2'd1)
            begin
                r.q1   = m;
                r.qlen = 2'd2;
            end
            r.emitted   = s.emitted + EMIT_W'(1);
            r.last_char = m;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/zcdp_cfg.sv */
// APB register file for the ZIP central directory parser: entry count,
// directory size and size limit. Depends on zcdp_pkg.
`default_nettype none
module zcdp_cfg
    import zcdp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_count    <= '0;
            cfg_reg.directory_size <= '0;
            cfg_reg.max_unpacked   <= UNPACK_DEFAULT;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_ENTRY_COUNT:    cfg_reg.entry_count    <= pwdata[15:0];
                REG_DIRECTORY_SIZE: cfg_reg.directory_size <= pwdata;
                REG_MAX_UNPACKED:   cfg_reg.max_unpacked   <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ENTRY_COUNT:    prdata = {16'd0, cfg_reg.entry_count};
            REG_DIRECTORY_SIZE: prdata = cfg_reg.directory_size;
            REG_MAX_UNPACKED:   prdata = cfg_reg.max_unpacked;
            default:            prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/zcdp_norm.sv */
// Name normalizer step: strips leading slashes and dot prefixes, then copies
// mapped characters into the two-entry queue. Depends on zcdp_pkg.
`default_nettype none
module zcdp_norm
    import zcdp_pkg::*;
(
    input  wire norm_state_t cur,
    input  wire logic [7:0]  b,
    input  wire logic        last_name_byte,
    output norm_state_t      nxt
);

    always_comb
    begin
        norm_state_t s;
        logic        done;
        s    = cur;
        done = 1'b0;
        if (s.phase == PH_LEAD)
        begin
            if (is_slash(b))
            begin
                done = 1'b1;
            end
            else
            begin
                s.phase = PH_DOT;
            end
        end
        if (!done && s.phase == PH_DOT)
        begin
            if (s.pending_dot)
            begin
                s.pending_dot = 1'b0;
                if (is_slash(b))
                begin
                    done = 1'b1;
                end
                else
                begin
                    s.phase = PH_COPY;
                    s       = produce_char(s, CH_DOT);
                end
            end
            else if (b == CH_DOT && !last_name_byte)
            begin
                s.pending_dot = 1'b1;
                done          = 1'b1;
            end
            else
            begin
                s.phase = PH_COPY;
            end
        end
        if (!done && s.phase == PH_COPY)
        begin
            if (b == CH_NUL)
            begin
                s.phase = PH_STOP;
            end
            else
            begin
                s = produce_char(s, b);
            end
        end
        nxt = s;
    end

endmodule
`default_nettype wire

/* hw/rtl/zip_central_directory_parser.sv */
// ZIP central directory parser, top level: input register, record parser and
// output register with skid stage. Depends on zcdp_pkg, zcdp_cfg, zcdp_norm.
//
// The block takes one central directory byte per beat on data_byte and returns
// name characters, one descriptor per record (accepted or skipped with a
// reason) and at most one fault, after which bytes are swallowed until reset.
// A byte is held in the input register, is parsed by short logic against the
// record state and its result (if any) lands in the output register, so the
// sustained rate is one byte per clock while results are taken. A two-deep
// output (register plus skid) keeps the input flowing while one result is
// stalled; the input stalls only once both output slots are full. Program
// entry_count, directory_size and max_unpacked over APB while the stream is
// idle; nothing needs clearing after reset.
`default_nettype none
module zip_central_directory_parser
    import zcdp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // byte stream
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    // results
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       kind,
    output logic [7:0]       name_char,
    output logic [15:0]      entry_number,
    output logic             is_deflate,
    output logic [31:0]      crc_value,
    output logic [31:0]      packed_size,
    output logic [31:0]      unpacked_size,
    output logic [31:0]      header_offset,
    output logic [7:0]       name_length,
    output logic [3:0]       skip_reason,
    output logic [1:0]       fault_code,
    output logic             last
);

    cfg_t        cfg;
    norm_state_t norm_out;

    logic        in_full_reg, in_full_next;
    logic [7:0]  in_byte_reg;
    logic        skid_valid_reg, out_valid_reg;
    res_t        skid_reg, out_reg;

    rec_t        rec_reg, rec_next;
    logic [31:0] bc_reg, bc_next;
    logic [15:0] rd_reg, rd_next;
    logic        halted_reg, halted_next;

    logic        go, accept, take, out_free;
    logic        res_valid;
    res_t        res;

    logic [POS_W-1:0] p, end_pos, name_off;
    logic [31:0]      hs_new;
    logic             norm_en, last_nb;
    logic [32:0]      start_sum;
    logic [33:0]      rec_sum;

    zcdp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign p        = rec_reg.position;
    assign name_off = p - POS_OFFSET;
    assign last_nb  = (name_off == POS_W'(rec_reg.name_bytes));
    assign norm_en  = (p >= POS_NAME) && ((p - POS_NAME) < POS_W'(rec_reg.name_bytes))
                      && (rec_reg.skip_code == SKIP_NONE);

    zcdp_norm u_norm (
        .cur            (rec_reg.norm),
        .b              (in_byte_reg),
        .last_name_byte (last_nb),
        .nxt            (norm_out)
    );

    // Parser advances only while the skid slot is free
    assign go         = !skid_valid_reg;
    assign byte_stall = in_full_reg && skid_valid_reg;
    assign accept     = byte_valid && !byte_stall;
    assign take       = out_valid_reg && !result_stall;
    assign out_free   = !out_valid_reg || take;

    assign hs_new    = {in_byte_reg, rec_reg.header_shift[31:8]};
    assign end_pos   = POS_OFFSET + POS_W'(rec_reg.name_bytes) + POS_W'(rec_reg.extra_bytes)
                       + POS_W'(rec_reg.comment_bytes);
    assign start_sum = {1'b0, bc_reg} + 33'd46;
    assign rec_sum   = {2'b0, bc_reg} + 34'd1 + 34'(rec_reg.name_bytes)
                       + 34'(rec_reg.extra_bytes) + 34'(rec_reg.comment_bytes);

    always_comb
    begin
        logic [3:0]  reason;
        logic [15:0] em16;
        rec_next    = rec_reg;
        bc_next     = bc_reg;
        rd_next     = rd_reg;
        halted_next = halted_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.entry_number = rd_reg;
        reason      = SKIP_NONE;
        em16        = '0;

        if (go && in_full_reg && !halted_reg)
        begin
            if (p == '0 && rd_reg >= cfg.entry_count)
            begin
                // all records parsed: drop the byte
            end
            else if (p == '0 && start_sum > {1'b0, cfg.directory_size})
            begin
                res_valid      = 1'b1;
                res.kind       = KIND_FAULT;
                res.fault_code = FAULT_OVERRUN;
                res.last       = 1'b1;
                halted_next    = 1'b1;
            end
            else if (p == POS_SIG && hs_new != SIG_CENTRAL)
            begin
                res_valid      = 1'b1;
                res.kind       = KIND_FAULT;
                res.fault_code = FAULT_SIGNATURE;
                res.last       = 1'b1;
                halted_next    = 1'b1;
            end
            else if (p == POS_OFFSET && rec_sum > {2'b0, cfg.directory_size})
            begin
                res_valid      = 1'b1;
                res.kind       = KIND_FAULT;
                res.fault_code = FAULT_OVERRUN;
                res.last       = 1'b1;
                halted_next    = 1'b1;
            end
            else
            begin
                bc_next               = bc_reg + 32'd1;
                rec_next.header_shift = hs_new;
                case (p)
                    POS_FLAGS:   rec_next.flag_word     = hs_new[31:16];
                    POS_METHOD:  rec_next.method_word   = hs_new[31:16];
                    POS_CRC:     rec_next.crc_hold      = hs_new;
                    POS_PACKED:  rec_next.packed_hold   = hs_new;
                    POS_UNPACK:  rec_next.unpacked_hold = hs_new;
                    POS_NAMELEN: rec_next.name_bytes    = hs_new[31:16];
                    POS_EXTRA:   rec_next.extra_bytes   = hs_new[31:16];
                    POS_COMMENT: rec_next.comment_bytes = hs_new[31:16];
                    POS_OFFSET:
                    begin
                        rec_next.offset_hold = hs_new;
                        if (rec_reg.flag_word[0])
                            rec_next.skip_code = SKIP_ENCRYPTED;
                        else if (rec_reg.method_word != METHOD_STORE
                                 && rec_reg.method_word != METHOD_DEFLATE)
                            rec_next.skip_code = SKIP_METHOD;
                        else if (rec_reg.packed_hold == SIZE_ESCAPE
                                 || rec_reg.unpacked_hold == SIZE_ESCAPE)
                            rec_next.skip_code = SKIP_ESCAPE;
                        else if (rec_reg.unpacked_hold > cfg.max_unpacked)
                            rec_next.skip_code = SKIP_TOO_LARGE;
                        else if (rec_reg.name_bytes == '0
                                 || rec_reg.name_bytes >= 16'(NAME_LIMIT))
                            rec_next.skip_code = SKIP_NAME_LEN;
                    end
                    default: ;
                endcase

                if (norm_en)
                begin
                    rec_next.norm = norm_out;
                end

                if (p >= POS_OFFSET && p == end_pos)
                begin
                    // record ends: build the descriptor from the updated state
                    reason = rec_next.skip_code;
                    if (reason == SKIP_NONE)
                    begin
                        if (rec_next.norm.emitted == '0)
                            reason = SKIP_EMPTY;
                        else if (rec_next.norm.last_char == CH_SLASH)
                            reason = SKIP_DIRECTORY;
                        else if (rec_next.method_word == METHOD_STORE
                                 && rec_next.packed_hold != rec_next.unpacked_hold)
                            reason = SKIP_STORE;
                    end
                    em16              = 16'(rec_next.norm.emitted);
                    res_valid         = 1'b1;
                    res.kind          = (reason != SKIP_NONE) ? KIND_SKIP : KIND_ACCEPT;
                    res.name_char     = (rec_next.norm.qlen != 2'd0) ? rec_next.norm.q0 : 8'd0;
                    res.is_deflate    = (rec_next.method_word == METHOD_DEFLATE);
                    res.crc_value     = rec_next.crc_hold;
                    res.packed_size   = rec_next.packed_hold;
                    res.unpacked_size = rec_next.unpacked_hold;
                    res.header_offset = rec_next.offset_hold;
                    res.name_length   = (em16 > 16'd255) ? 8'hFF : em16[7:0];
                    res.skip_reason   = reason;
                    res.last          = ({1'b0, rd_reg} + 17'd1 == {1'b0, cfg.entry_count});
                    rd_next           = rd_reg + 16'd1;
                    rec_next          = '0;
                end
                else
                begin
                    rec_next.position = p + POS_W'(1);
                    if (p >= POS_NAME && rec_next.norm.qlen != 2'd0)
                    begin
                        // drain the queue head as a name character
                        res_valid          = 1'b1;
                        res.kind           = KIND_CHAR;
                        res.name_char      = rec_next.norm.q0;
                        rec_next.norm.q0   = rec_next.norm.q1;
                        rec_next.norm.q1   = 8'd0;
                        rec_next.norm.qlen = rec_next.norm.qlen - 2'd1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (accept)
            in_full_next = 1'b1;
        else if (go)
            in_full_next = 1'b0;
        else
            in_full_next = in_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            rec_reg        <= '0;
            bc_reg         <= '0;
            rd_reg         <= '0;
            halted_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            rec_reg     <= rec_next;
            bc_reg      <= bc_next;
            rd_reg      <= rd_next;
            halted_reg  <= halted_next;
            // hold results in output then skid, in order
            if (skid_valid_reg)
            begin
                if (out_free)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (res_valid)
            begin
                if (out_free)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= data_byte;
        if (skid_valid_reg)
        begin
            if (out_free)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (out_free)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign result_valid  = out_valid_reg;
    assign kind          = out_reg.kind;
    assign name_char     = out_reg.name_char;
    assign entry_number  = out_reg.entry_number;
    assign is_deflate    = out_reg.is_deflate;
    assign crc_value     = out_reg.crc_value;
    assign packed_size   = out_reg.packed_size;
    assign unpacked_size = out_reg.unpacked_size;
    assign header_offset = out_reg.header_offset;
    assign name_length   = out_reg.name_length;
    assign skip_reason   = out_reg.skip_reason;
    assign fault_code    = out_reg.fault_code;
    assign last          = out_reg.last;

endmodule
`default_nettype wire
